### hdl/fqs_pkg.sv
// Shared types and constants for the FIFO queue with key search.
// Used by the top level, its RAM wrapper user and the port checker.
package fqs_pkg;

  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned OUT_FIELD_W = DATA_W + POS_W + POS_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE
  } state_e;

  // One result word as it leaves the block
  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic [POS_W-1:0]         position;
    logic [POS_W-1:0]         occupancy;
  } res_t;

endpackage

### hdl/fqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fqs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fifo_queue_with_search.sv
// Flow: an enqueue or a refused op goes straight to S_DONE; a dequeue/peek reads the head
// entry and passes through S_READ; a search walks the RAM in S_SCAN, one entry a cycle,
// until a match or the last entry. S_DONE loads the result into the output register.
// One word in flight: s_axis_tready stays low until the result has left S_DONE.
// One result may wait in the output register without blocking; a second holds the FSM.
// Reset empties the queue (pointers and count to zero); RAM contents are not reset.
module fifo_queue_with_search #(
  parameter int unsigned DEPTH = fqs_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input words
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [fqs_pkg::DATA_W-1:0]         s_axis_tdata,  // [31:0] value
  input  logic [1:0]                         s_axis_tuser,  // [1:0] opcode
  // result words
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [fqs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [31:0] data, [36:32] position,
                                                            // [41:37] occupancy, rest zero
  output logic [1:0]                         m_axis_tuser   // [1:0] status
);

  import fqs_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  state_e                   state_q, state_d;
  logic [PTR_W-1:0]         head_q, head_d;
  logic [PTR_W-1:0]         tail_q, tail_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [PTR_W-1:0]         scan_ptr_q, scan_ptr_d;
  logic [CNT_W-1:0]         idx_q, idx_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  res_t                     res_q, res_d;
  res_t                     out_q;
  logic                     out_valid_q;
  logic                     out_load;

  logic                     ram_we;
  logic [PTR_W-1:0]         ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  logic                     in_acc;
  opcode_e                  op_in;
  logic [CNT_W-1:0]         idx_inc;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_LAST) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[POS_W-1:0];
  endfunction

  // entry store
  fqs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (s_axis_tdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign op_in         = opcode_e'(s_axis_tuser);
  assign idx_inc       = idx_q + CNT_W'(1);

  // next state, pointer updates and RAM control
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    scan_ptr_d = scan_ptr_q;
    idx_d      = idx_q;
    key_d      = key_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_raddr  = head_q;
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          key_d          = s_axis_tdata;
          res_d.data     = '0;
          res_d.status   = ST_OK;
          res_d.position = '0;
          state_d        = S_DONE;
          case (op_in)
            OP_ENQ: begin
              if (cnt_q == CNT_FULL) begin
                res_d.status = ST_FULL;
              end else begin
                ram_we = 1'b1;
                tail_d = next_ptr(tail_q);
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end
            OP_DEQ, OP_PEEK: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                // head entry is read this cycle, data lands in S_READ
                state_d = S_READ;
                if (op_in == OP_DEQ) begin
                  head_d = next_ptr(head_q);
                  cnt_d  = cnt_q - CNT_W'(1);
                end
              end
            end
            OP_SEARCH: begin
              if (cnt_q == '0) begin
                res_d.status = ST_NOTFOUND;
              end else begin
                idx_d      = '0;
                scan_ptr_d = next_ptr(head_q);
                state_d    = S_SCAN;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
          res_d.occupancy = to_pos(cnt_d);
        end
      end
      S_READ: begin
        res_d.data = ram_rdata;
        state_d    = S_DONE;
      end
      S_SCAN: begin
        // compare entry idx_q while the next one is being read
        ram_raddr  = scan_ptr_q;
        scan_ptr_d = next_ptr(scan_ptr_q);
        if (ram_rdata == key_q) begin
          res_d.position = to_pos(idx_inc);
          res_d.status   = ST_OK;
          state_d        = S_DONE;
        end else if (idx_inc == cnt_q) begin
          res_d.status = ST_NOTFOUND;
          state_d      = S_DONE;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_ptr_q <= scan_ptr_d;
    idx_q      <= idx_d;
    key_q      <= key_d;
    res_q      <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.occupancy, out_q.position, out_q.data};
  assign m_axis_tuser  = out_q.status;

endmodule

### hdl/fqs_checker.sv
// Port-level checks for the FIFO queue with key search, bound to the top level.
// Depends on fqs_pkg.
module fqs_port_assert #(
  parameter int unsigned DEPTH = fqs_pkg::DEPTH_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [fqs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                      m_axis_tuser
);

  import fqs_pkg::*;

  localparam logic [POS_W-1:0] OCC_FULL = POS_W'(DEPTH);

  logic             out_acc;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] occupancy;
  logic [DATA_W-1:0] data;

  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign data      = m_axis_tdata[DATA_W-1:0];
  assign position  = m_axis_tdata[DATA_W+POS_W-1:DATA_W];
  assign occupancy = m_axis_tdata[DATA_W+2*POS_W-1:DATA_W+POS_W];

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // empty status only with an empty queue and no data
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && m_axis_tuser == ST_EMPTY |-> occupancy == '0 && data == '0 && position == '0)
    else $error("empty status with entries or data");

  // full status only at full occupancy
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && m_axis_tuser == ST_FULL |-> occupancy == OCC_FULL && data == '0)
    else $error("full status below capacity");

  // a match position implies ok status and no data
  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && position != '0 |-> m_axis_tuser == ST_OK && data == '0)
    else $error("match position with wrong status or data");

endmodule

bind fifo_queue_with_search fqs_port_assert #(
  .DEPTH (DEPTH)
) u_fqs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/fqs_checker.sv
// Checker for the FIFO queue with key search: watches both stream ports,
// predicts each result word from its own queue model and compares it.
// Depends on fqs_pkg for opcodes, status codes, widths and the result layout.
module fqs_checker
  import fqs_pkg::*;
#(
  parameter int unsigned DEPTH = fqs_pkg::DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [DATA_W-1:0]      in_data_i,   // [31:0] value
  input  logic [1:0]             in_user_i,   // [1:0] opcode
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [OUT_TDATA_W-1:0] out_data_i,  // [31:0] data, [36:32] position,
                                              // [41:37] occupancy, rest zero
  input  logic [1:0]             out_user_i,  // [1:0] status
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     checked_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  // queue model
  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  rd_idx;
  logic [PTR_W-1:0]  wr_idx;
  int unsigned       fill;

  // results still owed by the block, oldest first
  res_t want_q[$];
  int   n_fail;
  int   n_checked;

  assign fail_count_o = n_fail;
  assign checked_o    = n_checked;

  function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // one queue operation against the model, returns the word it must produce
  task automatic apply_op(input opcode_e op, input logic [DATA_W-1:0] val,
                          output res_t r);
    logic [PTR_W-1:0] p;
    bit               hit;
    r          = '0;
    r.status   = ST_OK;
    hit        = 1'b0;
    case (op)
      OP_ENQ: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slots[wr_idx] = val;
          wr_idx        = next_idx(wr_idx);
          fill++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = slots[rd_idx];
          if (op == OP_DEQ) begin
            rd_idx = next_idx(rd_idx);
            fill--;
          end
        end
      end
      default: begin
        // walk from the oldest entry, first match wins
        p        = rd_idx;
        r.status = ST_NOTFOUND;
        for (int unsigned i = 0; i < fill; i++) begin
          if (!hit && slots[p] == val) begin
            hit        = 1'b1;
            r.status   = ST_OK;
            r.position = POS_W'(i + 1);
          end
          p = next_idx(p);
        end
      end
    endcase
    r.occupancy = POS_W'(fill);
  endtask

  task automatic flag_field(input string name, input logic [DATA_W-1:0] want,
                            input logic [DATA_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    n_fail++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    if (!rst_ni) begin
      rd_idx    = '0;
      wr_idx    = '0;
      fill      = 0;
      n_fail    = 0;
      n_checked = 0;
      want_q.delete();
      pending_o <= 0;
    end else begin
      // result side first: it always belongs to an earlier word
      if (out_valid_i && out_ready_i) begin
        n_checked++;
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result word %0h status %0h", $time, out_data_i,
                   out_user_i);
          n_fail++;
        end else begin
          want         = want_q.pop_front();
          got.data      = out_data_i[DATA_W-1:0];
          got.position  = out_data_i[DATA_W +: POS_W];
          got.occupancy = out_data_i[DATA_W+POS_W +: POS_W];
          if (got.data !== want.data)
            flag_field("data", want.data, got.data);
          if (out_user_i !== want.status)
            flag_field("status", DATA_W'(want.status), DATA_W'(out_user_i));
          if (got.position !== want.position)
            flag_field("position", DATA_W'(want.position), DATA_W'(got.position));
          if (got.occupancy !== want.occupancy)
            flag_field("occupancy", DATA_W'(want.occupancy), DATA_W'(got.occupancy));
          if (out_data_i[OUT_TDATA_W-1:OUT_FIELD_W] !== '0)
            flag_field("pad", '0, DATA_W'(out_data_i[OUT_TDATA_W-1:OUT_FIELD_W]));
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_op(opcode_e'(in_user_i), in_data_i, want);
        want_q.push_back(want);
      end
      pending_o <= want_q.size();
    end
  end

endmodule

### tb/tb_fifo_queue_with_search.sv
// Testbench top for the FIFO queue with key search: clock, reset, word
// stimulus and result back-pressure; checking is done by fqs_checker.
// Depends on fqs_pkg, fifo_queue_with_search and fqs_checker.
module tb_fifo_queue_with_search;
  import fqs_pkg::*;

  localparam int unsigned DEPTH    = DEPTH_DEF;
  localparam int unsigned N_RANDOM = 400;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [DATA_W-1:0]      s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  int fail_count;
  int pending;
  int checked;

  logic              hold_req;
  int                burst_left;
  int                n_op [4];
  logic [DATA_W-1:0] key_pool [8];

  fifo_queue_with_search #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  fqs_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_user_i  (m_axis_tuser),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("FAILURE");
    $finish;
  end

  // result side: changing stall patterns, plus one long hold-off
  initial begin
    int  mode;
    int  mode_left;
    int  hold_left;
    int  cyc;
    bit  held;
    m_axis_tready = 1'b0;
    mode_left     = 0;
    hold_left     = 0;
    cyc           = 0;
    held          = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (!held && hold_req) begin
        held      = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 40);
        end
        mode_left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 99) < 55);
          default: m_axis_tready <= (cyc % 5 < 3);
        endcase
      end
    end
  end

  // offer one word, idling between bursts, and hold it until taken
  task automatic send_word(input opcode_e op, input logic [DATA_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    n_op[op]++;
  endtask

  // stop offering until every owed result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    int          sent;
    int          phase_len;
    int          mode;
    int          roll;
    opcode_e     op;
    logic [DATA_W-1:0] val;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ENQ;
    hold_req      = 1'b0;
    burst_left    = 0;
    foreach (n_op[i]) n_op[i] = 0;
    key_pool = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h1, 32'h5, 32'h1234, 32'hdead_beef};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, fill with extremes, full, searches, wrap
    send_word(OP_DEQ, 32'h0);
    send_word(OP_PEEK, 32'hffff_ffff);
    send_word(OP_SEARCH, 32'h0);
    send_word(OP_ENQ, 32'h8000_0000);
    send_word(OP_ENQ, 32'h7fff_ffff);
    send_word(OP_ENQ, 32'h0);
    send_word(OP_ENQ, 32'hffff_ffff);
    for (int i = 4; i < DEPTH; i++)
      send_word(OP_ENQ, 32'h2468_ace0 + i);
    send_word(OP_ENQ, 32'h5555_5555);          // refused, queue full
    send_word(OP_SEARCH, 32'h7fff_ffff);       // second entry
    send_word(OP_SEARCH, 32'h2468_ace0 + DEPTH - 1);  // last entry
    send_word(OP_SEARCH, 32'h5555_5555);       // miss on a full queue
    send_word(OP_PEEK, 32'h0);
    send_word(OP_DEQ, 32'h0);
    send_word(OP_ENQ, 32'haaaa_aaaa);          // tail has wrapped, written to slot 0
    send_word(OP_SEARCH, 32'haaaa_aaaa);
    wait_drained();

    // random phases: fill-heavy, drain-heavy or mixed
    hold_req = 1'b1;
    sent     = 0;
    while (sent < N_RANDOM) begin
      mode      = $urandom_range(0, 2);
      phase_len = $urandom_range(30, 70);
      for (int k = 0; k < phase_len && sent < N_RANDOM; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       op = opcode_e'((roll < 60) ? OP_ENQ : (roll < 70) ? OP_DEQ :
                                  (roll < 80) ? OP_PEEK : OP_SEARCH);
          1:       op = opcode_e'((roll < 15) ? OP_ENQ : (roll < 70) ? OP_DEQ :
                                  (roll < 80) ? OP_PEEK : OP_SEARCH);
          default: op = opcode_e'((roll < 30) ? OP_ENQ : (roll < 55) ? OP_DEQ :
                                  (roll < 70) ? OP_PEEK : OP_SEARCH);
        endcase
        // pool values make duplicates and search hits likely
        if ($urandom_range(0, 99) < ((op == OP_SEARCH) ? 60 : 40))
          val = key_pool[$urandom_range(0, 7)];
        else
          val = $urandom;
        send_word(op, val);
        sent++;
      end
      if ($urandom_range(0, 1) == 0)
        wait_drained();
    end

    wait_drained();
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("Sent %0d enqueue, %0d dequeue, %0d peek and %0d search words;",
             n_op[OP_ENQ], n_op[OP_DEQ], n_op[OP_PEEK], n_op[OP_SEARCH]);
    $display("checked %0d result words through full, empty and wrap states, %0d errors.",
             checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
